### hdl/rmvs_pkg.sv
package rmvs_pkg;

  // Default widths of the sample and of the sample counter
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int COUNT_BITS_DEF  = 16;

  // Width of the M2 accumulator and of the shared divider's dividend
  localparam int DIV_W = 64;

  // Width of the square root result
  localparam int ROOT_W = 32;

  // Width of the reported variance
  localparam int VAR_W = 48;

endpackage

### hdl/rmvs_div.sv
module rmvs_div #(
  parameter int VW = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [rmvs_pkg::DIV_W-1:0] dividend,
  input  logic [VW-1:0]              divisor,
  output logic                       done,
  output logic [rmvs_pkg::DIV_W-1:0] quo
);
  import rmvs_pkg::*;

  localparam int CW = $clog2(DIV_W + 1);

  logic [CW-1:0]    cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DIV_W-1:0] quo_r;
  logic [VW:0]      rem_r;
  logic [VW-1:0]    dsr_r;
  logic [VW:0]      rem_t;

  // Bring down the next dividend bit
  assign rem_t = {rem_r[VW-1:0], quo_r[DIV_W-1]};

  // Restoring division, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(DIV_W);
        quo_r  <= dividend;
        dsr_r  <= divisor;
        rem_r  <= '0;
      end else if (busy_r) begin
        if (rem_t >= {1'b0, dsr_r}) begin
          rem_r <= rem_t - {1'b0, dsr_r};
          quo_r <= {quo_r[DIV_W-2:0], 1'b1};
        end else begin
          rem_r <= rem_t;
          quo_r <= {quo_r[DIV_W-2:0], 1'b0};
        end
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

### hdl/rmvs_mul.sv
module rmvs_mul #(
  parameter int W = 41
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [W-1:0]   op_a,
  input  logic [W-1:0]   op_b,
  output logic           done,
  output logic [2*W-1:0] prod
);
  import rmvs_pkg::*;

  localparam int CW = $clog2(W + 1);

  logic [CW-1:0]  cnt_r;
  logic           busy_r;
  logic           done_r;
  logic [2*W-1:0] acc_r;
  logic [2*W-1:0] a_r;
  logic [W-1:0]   b_r;

  // Shift-and-add, one multiplier bit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(W);
        acc_r  <= '0;
        a_r    <= (2*W)'(op_a);
        b_r    <= op_b;
      end else if (busy_r) begin
        if (b_r[0]) begin
          acc_r <= acc_r + a_r;
        end
        a_r   <= {a_r[2*W-2:0], 1'b0};
        b_r   <= {1'b0, b_r[W-1:1]};
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

### hdl/rmvs_sqrt.sv
module rmvs_sqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [2*rmvs_pkg::ROOT_W-1:0] rad,
  output logic                          done,
  output logic [rmvs_pkg::ROOT_W-1:0]   root
);
  import rmvs_pkg::*;

  localparam int CW = $clog2(ROOT_W + 1);

  logic [CW-1:0]       cnt_r;
  logic                busy_r;
  logic                done_r;
  logic [2*ROOT_W-1:0] rad_r;
  logic [ROOT_W+1:0]   rem_r;
  logic [ROOT_W-1:0]   root_r;
  logic [ROOT_W+3:0]   rem_t;
  logic [ROOT_W+3:0]   trial;

  // Bring down two radicand bits, try root*4+1
  assign rem_t = {rem_r, rad_r[2*ROOT_W-1 -: 2]};
  assign trial = (ROOT_W+4)'({root_r, 2'b01});

  // Digit-by-digit square root, one result bit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(ROOT_W);
        rad_r  <= rad;
        rem_r  <= '0;
        root_r <= '0;
      end else if (busy_r) begin
        if (rem_t >= trial) begin
          rem_r  <= (ROOT_W+2)'(rem_t - trial);
          root_r <= {root_r[ROOT_W-2:0], 1'b1};
        end else begin
          rem_r  <= (ROOT_W+2)'(rem_t);
          root_r <= {root_r[ROOT_W-2:0], 1'b0};
        end
        rad_r <= {rad_r[2*ROOT_W-3:0], 2'b00};
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

### hdl/running_mean_variance_stats.sv
// Channel  Direction  tdata                                   tuser
// in_      slave      sample_value[15:0]                      op
// out_     master     count,min,max,mean,variance,stddev      has_data,variance_valid,
//                                                             count_saturated
//
// One item at a time. A sample passes through the mean division, the M2 product,
// the variance division and the square root, all bit-serial, both divisions on the
// shared restoring divider; a clear or an item with fewer than two samples skips the
// variance division and root, and a sample at a full count skips the mean division and product.
// Reset (rst_n, synchronous) empties the statistics; no clearing pass.
// A new item is taken while a result still waits in the output register.
module running_mean_variance_stats #(
  parameter int SAMPLE_BITS = rmvs_pkg::SAMPLE_BITS_DEF,
  parameter int COUNT_BITS  = rmvs_pkg::COUNT_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [15:0]   in_tdata,   // sample_value[15:0]
  input  logic          in_tuser,   // op
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [159:0]  out_tdata,  // sample_count[15:0], min_value[31:16],
                                    // max_value[47:32], mean_value[79:48],
                                    // variance_value[127:80], stddev_value[159:128]
  output logic [2:0]    out_tuser   // has_data, variance_valid, count_saturated
);
  import rmvs_pkg::*;

  localparam int MAG = SAMPLE_BITS + 25;
  localparam int S   = SAMPLE_BITS;
  localparam int CB  = COUNT_BITS;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MDIV = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_CHK  = 3'd3;
  localparam logic [2:0] ST_VDIV = 3'd4;
  localparam logic [2:0] ST_SQRT = 3'd5;
  localparam logic [2:0] ST_DONE = 3'd6;

  logic [2:0]            state_r;
  logic [CB-1:0]         count_r;
  logic signed [S-1:0]   min_r;
  logic signed [S-1:0]   max_r;
  logic signed [MAG-1:0] mean_r;
  logic [DIV_W-1:0]      m2_r;
  logic signed [MAG-1:0] x_r;
  logic                  dneg_r;
  logic [MAG-1:0]        dmag_r;
  logic                  sat_r;
  logic [VAR_W-1:0]      var_r;
  logic [ROOT_W-1:0]     sd_r;
  logic                  out_valid_r;
  logic [159:0]          out_data_r;
  logic [2:0]            out_user_r;

  logic                  in_fire;
  logic signed [S-1:0]   s_in;
  logic signed [MAG-1:0] x_in;
  logic [MAG:0]          delta;
  logic [MAG:0]          delta_abs;
  logic [CB-1:0]         count_inc;
  logic signed [MAG-1:0] mean_new;
  logic [MAG:0]          err;
  logic [MAG:0]          err_abs;
  logic [127:0]          prod_sh;
  logic [DIV_W-1:0]      m2_add;
  logic [DIV_W:0]        m2_sum;
  logic [VAR_W-1:0]      var_sat;
  logic                  out_load;
  logic                  has_data;
  logic                  var_valid;
  logic signed [MAG-1:0] mean_q;

  logic                  div_start;
  logic [DIV_W-1:0]      div_dnd;
  logic [CB-1:0]         div_dsr;
  logic                  div_done;
  logic [DIV_W-1:0]      div_quo;
  logic                  mul_start;
  logic                  mul_done;
  logic [2*MAG-1:0]      mul_prod;
  logic                  sqrt_start;
  logic                  sqrt_done;
  logic [ROOT_W-1:0]     sqrt_root;

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;

  // Take the sample and form delta = x - mean
  assign s_in      = signed'(S'(32'(in_tdata)));
  assign x_in      = signed'({s_in[S-1], s_in, 24'b0});
  assign delta     = {x_in[MAG-1], x_in} - {mean_r[MAG-1], mean_r};
  assign delta_abs = delta[MAG] ? (MAG+1)'(-delta) : delta;
  assign count_inc = count_r + CB'(1);

  // Update the mean and form x - new mean
  assign mean_q   = signed'(div_quo[MAG-1:0]);
  assign mean_new = dneg_r ? (mean_r - mean_q) : (mean_r + mean_q);
  assign err      = {x_r[MAG-1], x_r} - {mean_new[MAG-1], mean_new};
  assign err_abs  = err[MAG] ? (MAG+1)'(-err) : err;

  // Scale the product down, saturate it and the variance quotient, and form the M2 sum
  assign prod_sh = 128'(mul_prod) >> 32;
  assign m2_add  = (|prod_sh[127:DIV_W]) ? '1 : prod_sh[DIV_W-1:0];
  assign m2_sum  = {1'b0, m2_r} + {1'b0, m2_add};
  assign var_sat = (|div_quo[DIV_W-1:VAR_W]) ? '1 : div_quo[VAR_W-1:0];

  // Steer the shared divider
  always_comb begin
    div_start = 1'b0;
    div_dnd   = DIV_W'(delta_abs[MAG-1:0]);
    div_dsr   = count_inc;
    if (state_r == ST_IDLE) begin
      div_start = in_fire && !in_tuser && (count_r != '1);
    end else if (state_r == ST_CHK) begin
      div_start = (count_r > CB'(1));
      div_dnd   = m2_r;
      div_dsr   = count_r - CB'(1);
    end
  end

  assign mul_start  = (state_r == ST_MDIV) && div_done;
  assign sqrt_start = (state_r == ST_VDIV) && div_done;
  assign out_load   = (state_r == ST_DONE) && (!out_valid_r || out_tready);

  rmvs_div #(.VW(CB)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dnd),
    .divisor  (div_dsr),
    .done     (div_done),
    .quo      (div_quo)
  );

  rmvs_mul #(.W(MAG)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .op_a  (dmag_r),
    .op_b  (err_abs[MAG-1:0]),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  rmvs_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sqrt_start),
    .rad   ({var_sat, 16'b0}),
    .done  (sqrt_done),
    .root  (sqrt_root)
  );

  // Sequence one item through the serial units
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      min_r   <= signed'({1'b0, {(S-1){1'b1}}});
      max_r   <= signed'({1'b1, {(S-1){1'b0}}});
      mean_r  <= '0;
      m2_r    <= '0;
      sat_r   <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            sat_r <= 1'b0;
            if (in_tuser) begin
              count_r <= '0;
              min_r   <= signed'({1'b0, {(S-1){1'b1}}});
              max_r   <= signed'({1'b1, {(S-1){1'b0}}});
              mean_r  <= '0;
              m2_r    <= '0;
              state_r <= ST_CHK;
            end else if (count_r == '1) begin
              sat_r   <= 1'b1;
              state_r <= ST_CHK;
            end else begin
              if (s_in < min_r) begin
                min_r <= s_in;
              end
              if (s_in > max_r) begin
                max_r <= s_in;
              end
              count_r <= count_inc;
              x_r     <= x_in;
              dneg_r  <= delta[MAG];
              dmag_r  <= delta_abs[MAG-1:0];
              state_r <= ST_MDIV;
            end
          end
        end
        ST_MDIV: begin
          if (div_done) begin
            mean_r  <= mean_new;
            state_r <= ST_MUL;
          end
        end
        ST_MUL: begin
          if (mul_done) begin
            m2_r    <= m2_sum[DIV_W] ? '1 : m2_sum[DIV_W-1:0];
            state_r <= ST_CHK;
          end
        end
        ST_CHK: begin
          if (count_r > CB'(1)) begin
            state_r <= ST_VDIV;
          end else begin
            var_r   <= '0;
            sd_r    <= '0;
            state_r <= ST_DONE;
          end
        end
        ST_VDIV: begin
          if (div_done) begin
            var_r   <= var_sat;
            state_r <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          if (sqrt_done) begin
            sd_r    <= sqrt_root;
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_load) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign has_data  = (count_r != '0);
  assign var_valid = (count_r > CB'(1));

  // Hold the result until its transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= {sd_r, var_r, 32'(mean_r >>> 8),
                     has_data ? 16'(max_r) : 16'd0,
                     has_data ? 16'(min_r) : 16'd0,
                     16'(count_r)};
      out_user_r <= {sat_r, var_valid, has_data};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // The input side opens only between items
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> (state_r == ST_IDLE))
    else $error("input ready outside idle");

  // A reported variance without two samples is a slip
  a_var_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[1]) |-> (out_tdata[159:80] == '0))
    else $error("variance reported without two samples");

  // Saturation is only flagged at a full count
  a_sat_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && sat_r) |-> (count_r == '1))
    else $error("saturation flagged below full count");

  // The multiplier finishes only while it is awaited
  a_mul_done: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> (state_r == ST_MUL))
    else $error("multiplier done outside its state");

endmodule

### sim/tb_running_mean_variance_stats.sv
`timescale 1ns / 1ps

module tb_running_mean_variance_stats;

  localparam int SBITS       = rmvs_pkg::SAMPLE_BITS_DEF;
  localparam int CBITS       = rmvs_pkg::COUNT_BITS_DEF;
  localparam int N_RANDOM    = 1950;
  localparam int IDLE_LIMIT  = 20000;
  localparam int DRAIN_WAIT  = 400;

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  typedef struct packed {
    logic        op;
    logic [15:0] sample;
  } stat_item_t;

  typedef struct packed {
    logic [15:0] count;
    logic [15:0] min_v;
    logic [15:0] max_v;
    logic [31:0] mean_v;
    logic [47:0] var_v;
    logic [31:0] sd_v;
    logic        has_data;
    logic        var_ok;
    logic        sat;
  } stat_result_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [15:0]  in_tdata = '0;
  logic         in_tuser = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [159:0] out_tdata;
  logic [2:0]   out_tuser;

  stat_item_t   pending_items[$];
  stat_result_t expected_stats[$];
  int           fail_count = 0;
  int           idle_cycles = 0;
  int           results_seen = 0;
  int           clears_sent = 0;
  int           saturations_seen = 0;
  bit           stim_done = 1'b0;
  bit           in_taken = 1'b0;

  // predictor state
  logic [CBITS-1:0]  st_count;
  logic signed [31:0] st_min, st_max;
  logic signed [63:0] st_mean;
  logic [63:0]       st_m2;

  always #5 clk = ~clk;

  running_mean_variance_stats u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  task automatic stats_reset();
    st_count = '0;
    st_min   = (32'sd1 <<< (SBITS - 1)) - 1;
    st_max   = -(32'sd1 <<< (SBITS - 1));
    st_mean  = '0;
    st_m2    = '0;
  endtask

  function automatic logic [63:0] isqrt(input logic [63:0] v);
    logic [63:0] res, bitv;
    res  = '0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Welford update plus the reported view of the statistics
  task automatic predict_stats(input stat_item_t it, output stat_result_t r);
    logic signed [63:0]  s, x, delta, n, q, dev2;
    logic [63:0]         a, b, addv, vq, root;
    logic [127:0]        prod;
    logic                sat;
    sat = 1'b0;
    if (it.op == OP_CLEAR) begin
      stats_reset();
    end else if (st_count == {CBITS{1'b1}}) begin
      sat = 1'b1;
    end else begin
      s = 64'($signed(it.sample[SBITS-1:0]));
      if (s < st_min) st_min = s[31:0];
      if (s > st_max) st_max = s[31:0];
      st_count = st_count + 1'b1;
      n     = 64'(st_count);
      x     = s <<< 24;
      delta = x - st_mean;
      st_mean = st_mean + delta / n;
      dev2  = x - st_mean;
      a     = delta < 0 ? -delta : delta;
      b     = dev2 < 0 ? -dev2 : dev2;
      prod  = a * b;
      addv  = (prod[127:96] != 0) ? '1 : prod[95:32];
      st_m2 = (st_m2 > ~addv) ? '1 : st_m2 + addv;
    end
    r = '0;
    r.count = st_count;
    r.sat   = sat;
    if (st_count > 0) begin
      q = st_mean >>> 8;
      r.mean_v   = q[31:0];
      r.min_v    = st_min[15:0];
      r.max_v    = st_max[15:0];
      r.has_data = 1'b1;
    end
    if (st_count > 1) begin
      vq = st_m2 / (64'(st_count) - 64'd1);
      if (vq > 64'hFFFF_FFFF_FFFF) vq = 64'hFFFF_FFFF_FFFF;
      r.var_v  = vq[47:0];
      root     = isqrt(vq << 16);
      r.sd_v   = root[31:0];
      r.var_ok = 1'b1;
    end
  endtask

  // note each input transfer for the driver
  always @(posedge clk) in_taken <= in_tvalid && in_tready;

  // driver: bursts of transfers with random gaps
  int burst_left = 0;
  int gap_left   = 0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_tvalid || in_taken) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_tvalid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          in_tvalid <= 1'b1;
          in_tuser  <= pending_items[0].op;
          in_tdata  <= pending_items[0].sample;
          void'(pending_items.pop_front());
          if (burst_left == 0) begin
            burst_left <= $urandom_range(12, 1);
            gap_left   <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(300, 0);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_tvalid <= 1'b0;
          stim_done <= 1'b1;
        end
      end
    end
  end

  // receiver stalls on its own pattern: quiet stretches and choppy stretches
  int stall_phase = 0;
  always @(negedge clk) begin
    stall_phase <= stall_phase + 1;
    if (!rst_n) out_tready <= 1'b0;
    else if ((stall_phase / 2000) % 3 == 0) out_tready <= 1'b1;
    else out_tready <= ($urandom_range(3, 0) != 0) && (stall_phase % 97 > 20);
  end

  // monitor: predict on input transfer, compare on output transfer
  always @(posedge clk) begin
    stat_result_t exp_r, got;
    stat_item_t   it;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        it.op = in_tuser;
        it.sample = in_tdata;
        if (it.op == OP_CLEAR) clears_sent++;
        predict_stats(it, exp_r);
        expected_stats.push_back(exp_r);
      end
      if (out_tvalid && out_tready) begin
        got.count    = out_tdata[15:0];
        got.min_v    = out_tdata[31:16];
        got.max_v    = out_tdata[47:32];
        got.mean_v   = out_tdata[79:48];
        got.var_v    = out_tdata[127:80];
        got.sd_v     = out_tdata[159:128];
        got.has_data = out_tuser[0];
        got.var_ok   = out_tuser[1];
        got.sat      = out_tuser[2];
        results_seen++;
        if (out_tuser[2]) saturations_seen++;
        if (expected_stats.size() == 0) begin
          $error("result with no expectation pending");
          fail_count++;
        end else begin
          exp_r = expected_stats.pop_front();
          if (got.count != exp_r.count) begin
            $error("sample_count exp %0d got %0d", exp_r.count, got.count); fail_count++;
          end
          if (got.min_v != exp_r.min_v) begin
            $error("min_value exp %h got %h", exp_r.min_v, got.min_v); fail_count++;
          end
          if (got.max_v != exp_r.max_v) begin
            $error("max_value exp %h got %h", exp_r.max_v, got.max_v); fail_count++;
          end
          if (got.mean_v != exp_r.mean_v) begin
            $error("mean_value exp %h got %h", exp_r.mean_v, got.mean_v); fail_count++;
          end
          if (got.var_v != exp_r.var_v) begin
            $error("variance_value exp %h got %h", exp_r.var_v, got.var_v); fail_count++;
          end
          if (got.sd_v != exp_r.sd_v) begin
            $error("stddev_value exp %h got %h", exp_r.sd_v, got.sd_v); fail_count++;
          end
          if (got.has_data != exp_r.has_data) begin
            $error("has_data exp %b got %b", exp_r.has_data, got.has_data); fail_count++;
          end
          if (got.var_ok != exp_r.var_ok) begin
            $error("variance_valid exp %b got %b", exp_r.var_ok, got.var_ok); fail_count++;
          end
          if (got.sat != exp_r.sat) begin
            $error("count_saturated exp %b got %b", exp_r.sat, got.sat); fail_count++;
          end
        end
      end
      // watchdog on cycles with no transfer on either side
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  always @(posedge clk) begin
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog expired with %0d results outstanding", expected_stats.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic stat_item_t mk(input logic op, input logic [15:0] v);
    stat_item_t t;
    t.op = op;
    t.sample = v;
    return t;
  endfunction

  initial begin
    int k, len, mode;
    stats_reset();
    // directed: empty state, extremes, single sample, clear with junk data
    pending_items.push_back(mk(OP_CLEAR, 16'hFFFF));
    pending_items.push_back(mk(OP_ADD, 16'h7FFF));
    pending_items.push_back(mk(OP_ADD, 16'h8000));
    pending_items.push_back(mk(OP_ADD, 16'h7FFF));
    pending_items.push_back(mk(OP_ADD, 16'h8000));
    pending_items.push_back(mk(OP_ADD, 16'h0000));
    pending_items.push_back(mk(OP_ADD, 16'hFFFF));
    pending_items.push_back(mk(OP_CLEAR, 16'h0000));
    pending_items.push_back(mk(OP_ADD, 16'hFFFF));
    pending_items.push_back(mk(OP_ADD, 16'hFFFF));
    pending_items.push_back(mk(OP_ADD, 16'h0001));
    pending_items.push_back(mk(OP_CLEAR, 16'h5A5A));
    pending_items.push_back(mk(OP_ADD, 16'h8000));
    pending_items.push_back(mk(OP_ADD, 16'h8000));
    pending_items.push_back(mk(OP_ADD, 16'h8000));
    pending_items.push_back(mk(OP_CLEAR, 16'h0000));
    // random: runs of samples between clears, varied spread
    k = 0;
    while (k < N_RANDOM) begin
      len  = $urandom_range(60, 1);
      mode = $urandom_range(3, 0);
      for (int j = 0; j < len; j++) begin
        logic [15:0] v;
        case (mode)
          0: v = 16'($urandom);
          1: v = 16'(int'($urandom_range(40, 0)) - 20);
          2: v = $urandom_range(1, 0) ? 16'h7FFF : 16'h8000;
          default: v = 16'h1234 + 16'($urandom_range(255, 0));
        endcase
        pending_items.push_back(mk(OP_ADD, v));
      end
      pending_items.push_back(mk(OP_CLEAR, 16'($urandom)));
      k += len + 1;
    end
    pending_items.push_back(mk(OP_CLEAR, 16'h0000));
    pending_items.push_back(mk(OP_ADD, 16'h0042));

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    wait (stim_done && !in_tvalid);
    wait (expected_stats.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    $display("%0d results checked, %0d clears, %0d saturated samples",
             results_seen, clears_sent, saturations_seen);
    if (fail_count == 0 && expected_stats.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### running_mean_variance_stats.f
hdl/rmvs_pkg.sv
hdl/rmvs_div.sv
hdl/rmvs_mul.sv
hdl/rmvs_sqrt.sv
hdl/running_mean_variance_stats.sv
sim/tb_running_mean_variance_stats.sv
